// ===== rtl/core/ctt_pkg.sv =====
package ctt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 7;

    localparam logic [2:0] CMD_APPEND  = 3'd0;
    localparam logic [2:0] CMD_REPLACE = 3'd1;
    localparam logic [2:0] CMD_LOOKUP  = 3'd2;
    localparam logic [2:0] CMD_EXISTS  = 3'd3;
    localparam logic [2:0] CMD_REMOVE  = 3'd4;

    localparam logic [1:0] ANS_NONE    = 2'd0;
    localparam logic [1:0] ANS_YES     = 2'd1;
    localparam logic [1:0] ANS_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] card_id;
        logic [63:0] pass_upper;
        logic [63:0] pass_lower;
        logic        access_level;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         answer;
        logic               matched;
        logic               full_drop;
        logic [COUNT_W-1:0] entry_count;
    } res_t;

    typedef struct packed {
        logic [63:0] id;
        logic [63:0] pass_high;
        logic [63:0] pass_low;
        logic        access;
    } entry_t;

endpackage

// ===== rtl/core/ctt_entry_mem.sv =====
module ctt_entry_mem
    import ctt_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem_reg [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/credential_tag_table.sv =====
// channel | word     | handshake               | direction
// command | cmd_word | cmd_valid / cmd_ready   | in
// result  | res_word | res_valid / res_ready   | out
//
// Append and unknown commands go straight to the done state and then to the result register.
// Searches walk the table from entry 0, reading and then comparing each entry until a hit;
// a remove then moves each later entry down, reading it and writing it one place lower.
// The entry memory has a registered read, so reading and comparing are separate states.
// Reset empties the table (count to zero); entry storage is not cleared.
// cmd_ready is high only when the sequencer is idle; a stalled result waits
// in the output register while the next command is accepted.
module credential_tag_table
    import ctt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd_word,
    output logic res_valid,
    input  logic res_ready,
    output res_t res_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             item_reg, item_next;
    res_t             pend_reg, pend_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;

    logic [CNT_W:0]         idx_plus;
    logic                   more;
    logic                   hit;
    logic [CNT_W+COUNT_W-1:0] count_wide;
    entry_t                 item_entry;

    ctt_entry_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_plus   = {{(CNT_W + 1 - IDX_W){1'b0}}, idx_reg} + 1'b1;
    assign more       = idx_plus < {1'b0, count_reg};
    assign count_wide = {{COUNT_W{1'b0}}, count_reg};
    assign item_entry = '{id: item_reg.card_id, pass_high: item_reg.pass_upper,
                          pass_low: item_reg.pass_lower, access: item_reg.access_level};
    assign hit = (item_reg.command == CMD_REPLACE)
               ? (rd_data.id == item_reg.card_id)
               : (rd_data.pass_high == item_reg.pass_upper
                  && rd_data.pass_low == item_reg.pass_lower);

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        item_next      = item_reg;
        pend_next      = pend_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = item_entry;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next = cmd_word;
                    idx_next  = '0;
                    pend_next = '0;
                    state_next = S_DONE;
                    priority if (cmd_word.command == CMD_APPEND)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            pend_next.full_drop = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[IDX_W-1:0];
                            wr_data    = '{id: cmd_word.card_id,
                                           pass_high: cmd_word.pass_upper,
                                           pass_low: cmd_word.pass_lower,
                                           access: cmd_word.access_level};
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (cmd_word.command == CMD_REPLACE
                             || cmd_word.command == CMD_LOOKUP
                             || cmd_word.command == CMD_EXISTS
                             || cmd_word.command == CMD_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            if (cmd_word.command == CMD_LOOKUP)
                            begin
                                pend_next.answer = ANS_UNKNOWN;
                            end
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (hit)
                begin
                    pend_next.matched = 1'b1;
                    state_next        = S_DONE;
                    priority if (item_reg.command == CMD_REPLACE)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (item_reg.command == CMD_LOOKUP)
                    begin
                        pend_next.answer = {1'b0, rd_data.access};
                    end
                    else if (item_reg.command == CMD_EXISTS)
                    begin
                        pend_next.answer = ANS_YES;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
                else if (more)
                begin
                    idx_next   = idx_plus[IDX_W-1:0];
                    state_next = S_RD;
                end
                else
                begin
                    if (item_reg.command == CMD_LOOKUP)
                    begin
                        pend_next.answer = ANS_UNKNOWN;
                    end
                    state_next = S_DONE;
                end
            end
            S_SH_RD:
            begin
                if (more)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_plus[IDX_W-1:0];
                    state_next = S_SH_WR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                idx_next   = idx_plus[IDX_W-1:0];
                state_next = S_SH_RD;
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next       = 1'b1;
                    res_next             = pend_reg;
                    res_next.entry_count = count_wide[COUNT_W-1:0];
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        item_reg <= item_next;
        pend_reg <= pend_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg == $past(count_reg)
             || count_reg == $past(count_reg) + 1'b1
             || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count moved by more than one");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_CMP || state_reg == S_SH_WR)
        |-> ({1'b0, idx_reg} < {1'b0, count_reg}))
        else $error("scan index beyond held entries");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && pend_reg.full_drop)
        |-> (count_reg == CNT_W'(CAPACITY) && item_reg.command == CMD_APPEND))
        else $error("drop flagged on a table that is not full");

endmodule

// ===== tb/sv/tb_credential_tag_table.sv =====
module tb_credential_tag_table
    import ctt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 255;
    localparam int POOL_SIZE    = 16;
    localparam int RECENT_MAX   = 32;
    localparam int DRAIN_CYCLES = 300;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd_word;
    logic res_valid;
    logic res_ready;
    res_t res_word;

    bit calm;

    logic [127:0] pass_pool [POOL_SIZE];
    logic [63:0]  id_pool [POOL_SIZE];
    logic [127:0] recent_pass [$];

    credential_tag_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    class table_scoreboard;
        entry_t cards [CAPACITY];
        int     held;
        res_t   pending_results [$];
        int     errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function int first_with_pass(logic [63:0] hi, logic [63:0] lo);
            for (int i = 0; i < held; i++)
            begin
                if (cards[i].pass_high == hi && cards[i].pass_low == lo)
                    return i;
            end
            return -1;
        endfunction

        function int first_with_id(logic [63:0] id);
            for (int i = 0; i < held; i++)
            begin
                if (cards[i].id == id)
                    return i;
            end
            return -1;
        endfunction

        function void apply_command(cmd_t c);
            res_t   r;
            entry_t e;
            int     k;
            r = '0;
            e.id        = c.card_id;
            e.pass_high = c.pass_upper;
            e.pass_low  = c.pass_lower;
            e.access    = c.access_level;
            case (c.command)
                CMD_APPEND:
                begin
                    if (held >= CAPACITY)
                        r.full_drop = 1'b1;
                    else
                    begin
                        cards[held] = e;
                        held++;
                    end
                end
                CMD_REPLACE:
                begin
                    k = first_with_id(c.card_id);
                    if (k >= 0)
                    begin
                        r.matched = 1'b1;
                        cards[k]  = e;
                    end
                end
                CMD_LOOKUP:
                begin
                    k = first_with_pass(c.pass_upper, c.pass_lower);
                    if (k >= 0)
                    begin
                        r.matched = 1'b1;
                        r.answer  = cards[k].access ? ANS_YES : ANS_NONE;
                    end
                    else
                        r.answer = ANS_UNKNOWN;
                end
                CMD_EXISTS:
                begin
                    k = first_with_pass(c.pass_upper, c.pass_lower);
                    if (k >= 0)
                    begin
                        r.matched = 1'b1;
                        r.answer  = ANS_YES;
                    end
                end
                CMD_REMOVE:
                begin
                    k = first_with_pass(c.pass_upper, c.pass_lower);
                    if (k >= 0)
                    begin
                        r.matched = 1'b1;
                        for (int i = k; i + 1 < held; i++)
                            cards[i] = cards[i + 1];
                        held--;
                    end
                end
                default:
                begin
                end
            endcase
            r.entry_count = COUNT_W'(held);
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(res_t r);
            res_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result word", 64'(r), 64'd0);
                return;
            end
            want = pending_results.pop_front();
            if (r.answer !== want.answer)
                report_mismatch("answer", 64'(r.answer), 64'(want.answer));
            if (r.matched !== want.matched)
                report_mismatch("matched", 64'(r.matched), 64'(want.matched));
            if (r.full_drop !== want.full_drop)
                report_mismatch("full_drop", 64'(r.full_drop), 64'(want.full_drop));
            if (r.entry_count !== want.entry_count)
                report_mismatch("entry_count", 64'(r.entry_count), 64'(want.entry_count));
        endtask

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    table_scoreboard sb = new();

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic cmd_t make_word(logic [2:0] op, logic [63:0] id, logic [127:0] pass,
                                       logic acc);
        cmd_t c;
        c.command      = op;
        c.card_id      = id;
        c.pass_upper   = pass[127:64];
        c.pass_lower   = pass[63:0];
        c.access_level = acc;
        return c;
    endfunction

    function automatic logic [127:0] pick_pass();
        int r;
        logic [127:0] p;
        r = $urandom_range(0, 99);
        if (r < 75)
            return pass_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 90 && recent_pass.size() > 0)
            return recent_pass[$urandom_range(0, recent_pass.size() - 1)];
        p = {rand64(), rand64()};
        recent_pass.push_back(p);
        if (recent_pass.size() > RECENT_MAX)
            void'(recent_pass.pop_front());
        return p;
    endfunction

    function automatic cmd_t random_word(int append_w, int remove_w);
        int r;
        logic [2:0] op;
        logic [63:0] id;
        r = $urandom_range(0, 99);
        if (r < 3)
            op = 3'($urandom_range(int'(CMD_REMOVE) + 1, 7));
        else if (r < 3 + append_w)
            op = CMD_APPEND;
        else if (r < 3 + append_w + remove_w)
            op = CMD_REMOVE;
        else
            op = 3'($urandom_range(int'(CMD_REPLACE), int'(CMD_EXISTS)));
        id = ($urandom_range(0, 99) < 80) ? id_pool[$urandom_range(0, POOL_SIZE - 1)] : rand64();
        return make_word(op, id, pick_pass(), 1'($urandom));
    endfunction

    task send_word(cmd_t c);
        int gap;
        @(negedge clk);
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        sb.apply_command(c);
    endtask

    task wait_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int gap;
            @(negedge clk);
            gap = calm ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                res_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
            sb.check_result(res_word);
        end
    end

    initial
    begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [127:0] zeros;
        logic [127:0] ones;
        int append_w [RAND_PHASES];
        int remove_w [RAND_PHASES];

        append_w = '{30, 70, 30, 10, 35, 70};
        remove_w = '{20, 5, 30, 60, 25, 5};

        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_word  = '0;
        calm      = 1'b0;

        zeros = '0;
        ones  = '1;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pass_pool[i] = {rand64(), rand64()};
            id_pool[i]   = rand64();
        end
        pass_pool[0] = zeros;
        pass_pool[1] = ones;
        // near misses on a single bit of either half
        pass_pool[3] = pass_pool[2] ^ 128'd1;
        pass_pool[4] = pass_pool[2] ^ (128'd1 << 127);
        pass_pool[5] = pass_pool[2] ^ (128'd1 << 64);
        id_pool[0]   = '0;
        id_pool[1]   = '1;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table
        send_word(make_word(CMD_LOOKUP, id_pool[0], zeros, 1'b0));
        send_word(make_word(CMD_EXISTS, id_pool[0], ones, 1'b0));
        send_word(make_word(CMD_REMOVE, id_pool[0], zeros, 1'b0));
        send_word(make_word(CMD_REPLACE, id_pool[0], ones, 1'b1));
        // fill a few, field extremes
        send_word(make_word(CMD_APPEND, id_pool[0], zeros, 1'b0));
        send_word(make_word(CMD_APPEND, id_pool[1], ones, 1'b1));
        send_word(make_word(CMD_APPEND, id_pool[2], pass_pool[2], 1'b1));
        send_word(make_word(CMD_APPEND, id_pool[3], pass_pool[3], 1'b0));
        send_word(make_word(CMD_LOOKUP, rand64(), zeros, 1'b1));
        send_word(make_word(CMD_LOOKUP, rand64(), ones, 1'b0));
        send_word(make_word(CMD_LOOKUP, rand64(), pass_pool[3], 1'b1));
        send_word(make_word(CMD_LOOKUP, rand64(), pass_pool[4], 1'b1));
        send_word(make_word(CMD_EXISTS, rand64(), pass_pool[5], 1'b0));
        send_word(make_word(CMD_EXISTS, rand64(), ones, 1'b0));
        // replace rewrites the whole entry, old passcode gone
        send_word(make_word(CMD_REPLACE, id_pool[1], pass_pool[6], 1'b0));
        send_word(make_word(CMD_LOOKUP, rand64(), ones, 1'b1));
        send_word(make_word(CMD_LOOKUP, rand64(), pass_pool[6], 1'b1));
        // duplicate passcode: first in order wins, then the later one after removal
        send_word(make_word(CMD_APPEND, id_pool[4], pass_pool[2], 1'b0));
        send_word(make_word(CMD_LOOKUP, rand64(), pass_pool[2], 1'b0));
        send_word(make_word(CMD_REMOVE, rand64(), pass_pool[2], 1'b1));
        send_word(make_word(CMD_LOOKUP, rand64(), pass_pool[2], 1'b1));
        // undefined command codes
        send_word(make_word(CMD_REMOVE + 3'd1, rand64(), {rand64(), rand64()}, 1'b1));
        send_word(make_word(3'h7, rand64(), zeros, 1'b0));
        // remove head and tail
        send_word(make_word(CMD_REMOVE, rand64(), zeros, 1'b0));
        send_word(make_word(CMD_REMOVE, rand64(), pass_pool[2], 1'b0));

        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            calm = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_word(random_word(append_w[ph], remove_w[ph]));
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== credential_tag_table.f =====
rtl/core/ctt_pkg.sv
rtl/core/ctt_entry_mem.sv
rtl/core/credential_tag_table.sv
tb/sv/tb_credential_tag_table.sv
